### sv/suset_pkg.sv
// Shared constants and types for the sorted unique set block.
package suset_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // Element count at which an insert of a new value is refused.
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

endpackage

### sv/sorted_unique_set.sv
// Top level of the sorted unique set: sequencer, compare unit and element store.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a
// store with one write port and a registered read port. An item (operation,
// value) is taken on a rising edge with start high and busy low; busy then
// stays high until the whole listing has been issued. Each item goes through
// up to four phases, and only the search uses the one signed compare:
//   search  : first element not below value (the position is count when
//             every element is below),
//   decide  : picks the status,
//   shift   : a new insert moves the tail up, a delete that finds its value
//             moves it down; other items skip this phase,
//   listing : one result per element of the new set.
// Search and shift split the set at the position; no new item is taken while
// busy is high.
// Each result stays on the o_ ports for one cycle with o_strobe high; the
// receiver cannot stall. Every result of an item carries the same status and
// the new count, the final one has o_last set, and an empty set gives one
// result with o_element_valid low. Reset empties the set and returns to idle.
module sorted_unique_set (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic signed [suset_pkg::DATA_W-1:0]    i_value,
    output logic                                   o_strobe,
    output logic        [suset_pkg::STATUS_W-1:0]  o_status,
    output logic        [suset_pkg::CNT_W-1:0]     o_set_count,
    output logic signed [suset_pkg::DATA_W-1:0]    o_element_value,
    output logic                                   o_element_valid,
    output logic                                   o_last
);
    import suset_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SHUP   = 6'b001000,
        S_SHDN   = 6'b010000,
        S_LIST   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    t_op                        r_op, n_op;
    logic signed [DATA_W-1:0]   r_value, n_value;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_pos, n_pos;
    logic                       r_present, n_present;
    t_status                    r_status, n_status;
    logic [CNT_W-1:0]           r_ridx, n_ridx;
    logic [CNT_W-1:0]           r_cidx, n_cidx;
    logic                       r_rv, n_rv;
    logic signed [DATA_W-1:0]   r_rdata;

    logic                       r_o_stb, n_o_stb;
    t_status                    r_o_status, n_o_status;
    logic [CNT_W-1:0]           r_o_count, n_o_count;
    logic signed [DATA_W-1:0]   r_o_value, n_o_value;
    logic                       r_o_valid, n_o_valid;
    logic                       r_o_last, n_o_last;

    logic [DATA_W-1:0]          r_mem [CAPACITY];
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [DATA_W-1:0]          mem_wdata;

    logic [CNT_W-1:0]           cidx_inc, cidx_dec, ridx_inc, ridx_dec;
    logic                       data_below, data_equal;

    assign cidx_inc   = r_cidx + 1'b1;
    assign cidx_dec   = r_cidx - 1'b1;
    assign ridx_inc   = r_ridx + 1'b1;
    assign ridx_dec   = r_ridx - 1'b1;

    // The compare unit, used by the search: store data against the item's value.
    assign data_below = r_rdata < r_value;
    assign data_equal = r_rdata == r_value;

    // Element store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= $signed(r_mem[mem_raddr]);
    end

    // Sequencer: search, decide, shift and listing over the element store.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_value    = r_value;
        n_count    = r_count;
        n_pos      = r_pos;
        n_present  = r_present;
        n_status   = r_status;
        n_ridx     = r_ridx;
        n_cidx     = r_cidx;
        n_rv       = 1'b0;
        n_o_stb    = 1'b0;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_value  = r_o_value;
        n_o_valid  = r_o_valid;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_waddr  = r_pos[ADDR_W-1:0];
        mem_wdata  = r_value;
        mem_raddr  = r_ridx[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_value = i_value;
                    n_ridx  = '0;
                    n_state = S_SEARCH;
                end
            end

            S_SEARCH: begin
                // Read ahead one entry per cycle while entries remain.
                if (r_ridx < r_count) begin
                    n_rv   = 1'b1;
                    n_cidx = r_ridx;
                    n_ridx = ridx_inc;
                end
                // Stop at the first element not below the value.
                if (r_rv && !data_below) begin
                    n_pos     = r_cidx;
                    n_present = data_equal;
                    n_rv      = 1'b0;
                    n_state   = S_DECIDE;
                end else if (!r_rv && r_ridx >= r_count) begin
                    n_pos     = r_count;
                    n_present = 1'b0;
                    n_state   = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_ridx = '0;
                n_state = S_LIST;
                if (r_op == OP_INSERT) begin
                    if (r_present) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_count >= CAP_COUNT) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_INSERTED;
                        n_ridx   = r_count;
                        n_state  = S_SHUP;
                    end
                end else begin
                    if (r_present) begin
                        n_status = ST_DELETED;
                        n_ridx   = r_pos + 1'b1;
                        n_state  = S_SHDN;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end

            S_SHUP: begin
                // Move entries from the top down to the insert position up one place.
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = cidx_inc[ADDR_W-1:0];
                    mem_wdata = r_rdata;
                end
                if (r_ridx > r_pos) begin
                    mem_raddr = ridx_dec[ADDR_W-1:0];
                    n_rv      = 1'b1;
                    n_cidx    = ridx_dec;
                    n_ridx    = ridx_dec;
                end else if (!r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[ADDR_W-1:0];
                    mem_wdata = r_value;
                    n_count   = r_count + 1'b1;
                    n_ridx    = '0;
                    n_state   = S_LIST;
                end
            end

            S_SHDN: begin
                // Move entries above the deleted one down one place.
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = cidx_dec[ADDR_W-1:0];
                    mem_wdata = r_rdata;
                end
                if (r_ridx < r_count) begin
                    n_rv   = 1'b1;
                    n_cidx = r_ridx;
                    n_ridx = ridx_inc;
                end else if (!r_rv) begin
                    n_count = r_count - 1'b1;
                    n_ridx  = '0;
                    n_state = S_LIST;
                end
            end

            S_LIST: begin
                n_o_status = r_status;
                n_o_count  = r_count;
                if (r_count == '0) begin
                    // Empty set: one result that carries no element.
                    n_o_stb   = 1'b1;
                    n_o_value = '0;
                    n_o_valid = 1'b0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    if (r_ridx < r_count) begin
                        n_rv   = 1'b1;
                        n_cidx = r_ridx;
                        n_ridx = ridx_inc;
                    end
                    if (r_rv) begin
                        n_o_stb   = 1'b1;
                        n_o_value = r_rdata;
                        n_o_valid = 1'b1;
                        n_o_last  = (cidx_inc == r_count);
                        if (cidx_inc == r_count) begin
                            n_rv    = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_o_stb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_o_stb <= n_o_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_present  <= n_present;
        r_status   <= n_status;
        r_ridx     <= n_ridx;
        r_cidx     <= n_cidx;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_value  <= n_o_value;
        r_o_valid  <= n_o_valid;
        r_o_last   <= n_o_last;
    end

    // Outputs come straight from registers.
    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_o_stb;
    assign o_status        = r_o_status;
    assign o_set_count     = r_o_count;
    assign o_element_value = r_o_value;
    assign o_element_valid = r_o_valid;
    assign o_last          = r_o_last;

endmodule

### test/testbench.sv
// Self-checking testbench for the sorted unique set block.
`timescale 1ns / 100ps

module testbench;
    import suset_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last result for stray results to show up.
    localparam int END_SETTLE     = 120;
    localparam int POOL_SIZE      = 48;

    typedef struct {
        t_status                   status;
        logic [CNT_W-1:0]          set_count;
        logic signed [DATA_W-1:0]  element_value;
        logic                      element_valid;
        logic                      last;
    } t_listing_entry;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_operation;
    logic signed [DATA_W-1:0]    i_value;
    logic                        o_strobe;
    logic [STATUS_W-1:0]         o_status;
    logic [CNT_W-1:0]            o_set_count;
    logic signed [DATA_W-1:0]    o_element_value;
    logic                        o_element_valid;
    logic                        o_last;

    // Predicted contents of the set, kept in ascending order.
    logic signed [DATA_W-1:0]    held_values[$];
    // Listing results still owed by the block, oldest first.
    t_listing_entry              expected_listing[$];
    // Values drawn often so that duplicates and hits on delete are common.
    logic signed [DATA_W-1:0]    value_pool[POOL_SIZE];
    int                          error_count;
    int                          max_gap;
    int                          stall_cycles;

    sorted_unique_set dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_set_count     (o_set_count),
        .o_element_value (o_element_value),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one operation to the predicted set and queue the listing it causes.
    task automatic predict_listing(input t_op op, input logic signed [DATA_W-1:0] val);
        int             pos;
        bit             present;
        t_status        st;
        t_listing_entry entry;
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < val) pos++;
        present = (pos < held_values.size()) && (held_values[pos] == val);
        if (op == OP_INSERT) begin
            if (present) begin
                st = ST_DUPLICATE;
            end else if (held_values.size() >= CAPACITY) begin
                st = ST_FULL;
            end else begin
                held_values.insert(pos, val);
                st = ST_INSERTED;
            end
        end else if (present) begin
            held_values.delete(pos);
            st = ST_DELETED;
        end else begin
            st = ST_NOT_FOUND;
        end
        entry.status = st;
        entry.set_count = CNT_W'(held_values.size());
        if (held_values.size() == 0) begin
            entry.element_value = '0;
            entry.element_valid = 1'b0;
            entry.last = 1'b1;
            expected_listing.push_back(entry);
        end else begin
            for (int k = 0; k < held_values.size(); k++) begin
                entry.element_value = held_values[k];
                entry.element_valid = 1'b1;
                entry.last = (k == held_values.size() - 1);
                expected_listing.push_back(entry);
            end
        end
    endtask

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(input t_op op, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = $urandom_range(0, max_gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_listing(op, val);
    endtask

    // Hold the sender off until every owed result has arrived.
    task automatic wait_for_listing;
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_listing.size() != 0) @(posedge i_clk);
    endtask

    // Draw a value: pool entries, values already held, or anything at all.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 7 && held_values.size() > 0)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        return $urandom();
    endfunction

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_listing_entry exp_entry;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_listing.size() == 0) begin
                $error("unexpected result: status %0d, set_count %0d, element_value %0d",
                       o_status, o_set_count, o_element_value);
                error_count++;
            end else begin
                exp_entry = expected_listing.pop_front();
                if (o_status !== exp_entry.status) begin
                    $error("status: expected %0d, actual %0d", exp_entry.status, o_status);
                    error_count++;
                end
                if (o_set_count !== exp_entry.set_count) begin
                    $error("set_count: expected %0d, actual %0d",
                           exp_entry.set_count, o_set_count);
                    error_count++;
                end
                if (o_element_value !== exp_entry.element_value) begin
                    $error("element_value: expected %0d, actual %0d",
                           exp_entry.element_value, o_element_value);
                    error_count++;
                end
                if (o_element_valid !== exp_entry.element_valid) begin
                    $error("element_valid: expected %0d, actual %0d",
                           exp_entry.element_valid, o_element_valid);
                    error_count++;
                end
                if (o_last !== exp_entry.last) begin
                    $error("last: expected %0d, actual %0d", exp_entry.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither an item nor a result moves.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Empty set, extremes of the value range, duplicates and misses.
    task automatic test_edge_values;
        send_item(OP_DELETE, 32'sd5);
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sh7FFF_FFFF);
        send_item(OP_DELETE, 32'sd7);
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_DELETE, 32'sh8000_0000);
        send_item(OP_DELETE, 32'sh7FFF_FFFF);
        send_item(OP_DELETE, -32'sd1);
        send_item(OP_INSERT, 32'sh5555_AAAA);
        wait_for_listing();
    endtask

    // Fill to capacity, then refused inserts, duplicates when full and a refill.
    task automatic test_full_set;
        logic signed [DATA_W-1:0] freed;
        while (held_values.size() < CAPACITY) send_item(OP_INSERT, $urandom());
        send_item(OP_INSERT, held_values[0] - 32'sd1 == held_values[0] ?
                  32'sd0 : held_values[0] - 32'sd1);
        send_item(OP_INSERT, held_values[0]);
        send_item(OP_INSERT, held_values[CAPACITY - 1]);
        freed = held_values[CAPACITY / 2];
        send_item(OP_DELETE, freed);
        send_item(OP_INSERT, freed);
        send_item(OP_INSERT, $urandom());
        wait_for_listing();
    endtask

    // Random operations with a given share of inserts.
    task automatic run_random_ops(input int count, input int insert_pct);
        t_op op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE;
            send_item(op, pick_value());
        end
    endtask

    // Random phases: insert-heavy growth, back-to-back items, delete-heavy shrinking, mixed.
    task automatic test_random_ops;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = $urandom();
        run_random_ops(100, 80);
        wait_for_listing();
        max_gap = 0;
        run_random_ops(60, 50);
        max_gap = 10;
        run_random_ops(90, 20);
        wait_for_listing();
        run_random_ops(60, 55);
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        error_count = 0;
        max_gap     = 10;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = 1'b0;
        i_value     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_values();
        test_full_set();
        test_random_ops();

        wait_for_listing();
        repeat (END_SETTLE) @(posedge i_clk);
        if (expected_listing.size() != 0) begin
            $error("%0d expected results never arrived", expected_listing.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sorted_unique_set.f
sv/suset_pkg.sv
sv/sorted_unique_set.sv
test/testbench.sv
